/* rtl/core/snd1_pkg.sv */
// shared types, parse mode codes and delta tables for the snd1 audio delta decoder
// no dependencies

package snd1_pkg;

  // input transaction payload
  typedef struct packed {
    logic [7:0]  in_byte;
    logic        chunk_start;
    logic [15:0] chunk_out_size;
  } in_t;

  // output transaction payload
  typedef struct packed {
    logic [7:0] sample;
    logic       last_of_run;
    logic       chunk_done;
  } out_t;

  // parse mode codes
  localparam logic [1:0] MODE_HDR  = 2'd0;
  localparam logic [1:0] MODE_TWO  = 2'd1;
  localparam logic [1:0] MODE_FOUR = 2'd2;
  localparam logic [1:0] MODE_RAW  = 2'd3;

  // header codes
  localparam logic [1:0] HDR_TWO   = 2'd0;
  localparam logic [1:0] HDR_FOUR  = 2'd1;
  localparam logic [1:0] HDR_DELTA = 2'd2;
  localparam logic [1:0] HDR_FILL  = 2'd3;

  localparam logic [15:0] SAMPLE_INIT = 16'h0080;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
  } snd1_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic last_step;
  } snd1_sts_t;

  // 2-bit delta table, sign-extended to the running sample width
  function automatic logic [15:0] delta2(input logic [1:0] c);
    logic [15:0] d;
    case (c)
      2'd0:    d = 16'hFFFE;
      2'd1:    d = 16'hFFFF;
      2'd2:    d = 16'h0000;
      default: d = 16'h0001;
    endcase
    return d;
  endfunction

  // 4-bit delta table, sign-extended to the running sample width
  function automatic logic [15:0] delta4(input logic [3:0] c);
    logic [15:0] d;
    case (c)
      4'd0:    d = 16'hFFF7;
      4'd1:    d = 16'hFFF8;
      4'd2:    d = 16'hFFFA;
      4'd3:    d = 16'hFFFB;
      4'd4:    d = 16'hFFFC;
      4'd5:    d = 16'hFFFD;
      4'd6:    d = 16'hFFFE;
      4'd7:    d = 16'hFFFF;
      4'd8:    d = 16'h0000;
      4'd9:    d = 16'h0001;
      4'd10:   d = 16'h0002;
      4'd11:   d = 16'h0003;
      4'd12:   d = 16'h0004;
      4'd13:   d = 16'h0005;
      4'd14:   d = 16'h0006;
      default: d = 16'h0008;
    endcase
    return d;
  endfunction

  // clamp a signed 16-bit running sample to 0..255
  function automatic logic [15:0] clamp_byte(input logic [15:0] s);
    logic [15:0] r;
    if (s[15]) begin
      r = 16'd0;
    end else if (s[14:8] != 7'd0) begin
      r = 16'd255;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

/* rtl/core/snd1_ctrl.sv */
// controller: takes one input transaction, then issues one step per output slot
// depends on snd1_pkg

module snd1_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  snd1_pkg::snd1_sts_t sts,
  output snd1_pkg::snd1_cmd_t cmd
);
  import snd1_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r;
  logic state_nxt;

  // commands
  assign in_stall = (state_r != ST_IDLE);
  assign cmd.load = (state_r == ST_IDLE) && in_valid;
  assign cmd.step = (state_r == ST_RUN) && sts.out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.step && sts.last_step) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  a_step_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> state_r == ST_RUN) else $error("step issued outside run");
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.last_step) |=> state_r == ST_IDLE)
    else $error("run did not end on last step");
  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_RUN && !cmd.load)) else $error("load did not start run");

endmodule

/* rtl/core/snd1_datapath.sv */
// datapath: parser state, running sample, budget, step counter and output register
// depends on snd1_pkg

module snd1_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  snd1_pkg::in_t       in_data,
  input  snd1_pkg::snd1_cmd_t cmd,
  output snd1_pkg::snd1_sts_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output snd1_pkg::out_t      out_data
);
  import snd1_pkg::*;

  logic [7:0]  byte_r;
  logic [5:0]  step_r,   step_nxt;
  logic [1:0]  mode_r,   mode_nxt;
  logic [5:0]  left_r,   left_nxt;
  logic [15:0] rs_r,     rs_nxt;
  logic [15:0] budget_r, budget_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r,  out_data_nxt;

  logic [15:0] val;
  logic        want_emit;
  logic        last_step;
  logic        emit_ok;
  logic [1:0]  pair;
  logic [3:0]  nib;

  // per-step decode of the held byte
  always_comb begin
    val       = rs_r;
    want_emit = 1'b0;
    last_step = 1'b1;
    mode_nxt  = mode_r;
    left_nxt  = left_r;
    rs_nxt    = rs_r;
    pair      = byte_r[1:0];
    nib       = byte_r[3:0];
    unique case (mode_r)
      MODE_HDR: begin
        unique case (byte_r[7:6])
          HDR_DELTA: begin
            if (byte_r[5]) begin
              val       = rs_r + {{11{byte_r[4]}}, byte_r[4:0]};
              rs_nxt    = val;
              want_emit = 1'b1;
            end else begin
              mode_nxt = MODE_RAW;
              left_nxt = byte_r[5:0];
            end
          end
          HDR_FILL: begin
            want_emit = 1'b1;
            last_step = (step_r == byte_r[5:0]);
          end
          HDR_TWO: begin
            mode_nxt = MODE_TWO;
            left_nxt = byte_r[5:0];
          end
          default: begin
            mode_nxt = MODE_FOUR;
            left_nxt = byte_r[5:0];
          end
        endcase
      end
      MODE_TWO: begin
        case (step_r[1:0])
          2'd0:    pair = byte_r[1:0];
          2'd1:    pair = byte_r[3:2];
          2'd2:    pair = byte_r[5:4];
          default: pair = byte_r[7:6];
        endcase
        val       = clamp_byte(rs_r + delta2(pair));
        rs_nxt    = val;
        want_emit = 1'b1;
        last_step = (step_r[1:0] == 2'd3);
      end
      MODE_FOUR: begin
        nib       = step_r[0] ? byte_r[7:4] : byte_r[3:0];
        val       = clamp_byte(rs_r + delta4(nib));
        rs_nxt    = val;
        want_emit = 1'b1;
        last_step = step_r[0];
      end
      default: begin
        val       = {8'd0, byte_r};
        rs_nxt    = val;
        want_emit = 1'b1;
      end
    endcase
    // end of a payload byte: count down the run or go back to headers
    if (mode_r != MODE_HDR && last_step) begin
      if (left_r == 6'd0) begin
        mode_nxt = MODE_HDR;
      end else begin
        left_nxt = left_r - 6'd1;
      end
    end
  end

  assign emit_ok       = want_emit && (budget_r != 16'd0);
  assign sts.last_step = last_step;
  assign sts.out_free  = !out_valid_r || !out_stall;

  // output register next value
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (!out_stall) out_valid_nxt = 1'b0;
    if (cmd.step && emit_ok) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.sample      = val[7:0];
      out_data_nxt.chunk_done  = (budget_r == 16'd1);
      out_data_nxt.last_of_run = last_step || (budget_r == 16'd1);
    end
  end

  // budget and step counter
  always_comb begin
    budget_nxt = budget_r;
    step_nxt   = step_r;
    if (cmd.step) begin
      step_nxt = step_r + 6'd1;
      if (emit_ok) budget_nxt = budget_r - 16'd1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r        <= SAMPLE_INIT;
      mode_r      <= MODE_HDR;
      left_r      <= 6'd0;
      budget_r    <= 16'd0;
      step_r      <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        step_r <= 6'd0;
        if (in_data.chunk_start) begin
          rs_r     <= SAMPLE_INIT;
          mode_r   <= MODE_HDR;
          left_r   <= 6'd0;
          budget_r <= in_data.chunk_out_size;
        end
      end else if (cmd.step) begin
        step_r   <= step_nxt;
        budget_r <= budget_nxt;
        rs_r     <= rs_nxt;
        if (last_step) begin
          mode_r <= mode_nxt;
          left_r <= left_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) byte_r <= in_data.in_byte;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_no_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && budget_r == 16'd0) |=> budget_r == 16'd0)
    else $error("budget moved after exhaustion");
  a_mode_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !last_step) |=> $stable(mode_r)) else $error("mode changed mid byte");
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && emit_ok && budget_r == 16'd1) |=>
      (out_data_r.chunk_done && out_data_r.last_of_run && budget_r == 16'd0))
    else $error("budget end not flagged");

endmodule

/* rtl/core/snd1_audio_delta_decoder_unit.sv */
// top level of the snd1 audio delta decoder: controller plus datapath
// depends on snd1_pkg, snd1_ctrl, snd1_datapath
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   in_byte, chunk_start, chunk_out_size
//   out_     output     out_valid/out_stall sample, last_of_run, chunk_done
//
// a byte is taken, then decoded in max(1, n) steps, n being the sample slots it
// decodes, suppressed ones included: 4 for a 2-bit payload byte, 2 for a 4-bit one,
// up to 64 for a fill
// the step loop of the controller paces this, one sample through the output register
// per cycle; steps pause while out_stall holds a waiting sample
// in_stall is high from the cycle after a transaction until the last step
// rst_n is synchronous, active low; the sample starts at 128 and the budget at zero

module snd1_audio_delta_decoder_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  snd1_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output snd1_pkg::out_t out_data
);
  import snd1_pkg::*;

  snd1_cmd_t cmd;
  snd1_sts_t sts;

  // sequencing
  snd1_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // decode datapath
  snd1_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
